>>> src/dds_pkg.sv
package dds_pkg;

  // Wave values travel as offset-binary Q1.15 plus one: u = w + 1.0, 0..65536.
  localparam int WAVE_BITS = 17;
  localparam logic [WAVE_BITS-1:0] ONE_Q15 = 17'd32768;
  localparam logic [WAVE_BITS-1:0] FULL_Q15 = 17'd65536;

  // Configuration port.
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int STEP_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAVE_SHAPE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_CODE = 2'd2;

  // Reset values: 50 Hz at 8000 samples/s, and 60 V scaled to the DAC range.
  localparam logic [STEP_BITS-1:0] STEP_RESET = 32'd26843546;
  localparam int PEAK_RESET_BITS = 11;
  localparam logic [PEAK_RESET_BITS-1:0] PEAK_RESET = 11'd1100;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_SAWTOOTH = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_shape_t;

endpackage

>>> src/dds_phase.sv
module dds_phase #(
  parameter int PHASE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           restart,
  output logic                           in_ready,
  input  logic [dds_pkg::STEP_BITS-1:0]  phase_step,
  output logic                           phase_valid,
  output logic [PHASE_BITS-1:0]          phase,
  input  logic                           phase_ready
);
  import dds_pkg::*;

  logic [PHASE_BITS-1:0] phase_acc_r;
  logic [PHASE_BITS-1:0] phase_acc_nxt;
  logic [PHASE_BITS-1:0] phase_r;
  logic                  valid_r;
  logic [PHASE_BITS-1:0] step_aligned;
  logic [PHASE_BITS-1:0] phase_eval;
  logic                  advance;
  logic                  accept;

  // The step is in units of 2^-32 turn; line it up with the accumulator.
  generate
    if (PHASE_BITS >= STEP_BITS) begin : g_step_wide
      logic [PHASE_BITS:0] step_ext;
      assign step_ext     = {phase_step, {(PHASE_BITS - STEP_BITS + 1){1'b0}}} >> 1;
      assign step_aligned = step_ext[PHASE_BITS-1:0];
    end else begin : g_step_narrow
      assign step_aligned = phase_step[STEP_BITS-1 -: PHASE_BITS];
    end
  endgenerate

  assign advance  = !valid_r || phase_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  assign phase_eval    = restart ? '0 : phase_acc_r;
  assign phase_acc_nxt = phase_eval + step_aligned;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      valid_r     <= 1'b0;
    end else begin
      if (accept) begin
        phase_acc_r <= phase_acc_nxt;
      end
      if (advance) begin
        valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      phase_r <= phase_eval;
    end
  end

  assign phase_valid = valid_r;
  assign phase       = phase_r;

endmodule

>>> src/dds_wave.sv
module dds_wave #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           phase_valid,
  input  logic [PHASE_BITS-1:0]          phase,
  output logic                           phase_ready,
  input  dds_pkg::wave_shape_t           wave_shape,
  output logic                           wave_valid,
  output logic [dds_pkg::WAVE_BITS-1:0]  wave_u,
  input  logic                           wave_ready
);
  import dds_pkg::*;

  localparam int QUARTER = SINE_TABLE_DEPTH / 4;
  localparam int R_BITS  = $clog2(QUARTER);
  localparam int SEL_BITS = R_BITS + 1;
  localparam logic [63:0] QUARTER_W     = 64'(QUARTER);
  localparam logic [63:0] TWO_QUARTER_W = 64'(2 * QUARTER);
  localparam logic [63:0] PI_Q30        = 64'd3373259426;
  localparam logic [63:0] TAYLOR_DIV [1:12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef logic [QUARTER:0][WAVE_BITS-1:0] sine_tab_t;

  // Quarter-wave sine, Taylor series in unsigned Q30, rounded to Q15.
  function automatic sine_tab_t build_tab();
    sine_tab_t          tab;
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    tab = '0;
    for (int k = 0; k <= QUARTER; k++) begin
      x    = (PI_Q30 * 64'(k) + QUARTER_W) / TWO_QUARTER_W;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 12; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / TAYLOR_DIV[n];
        if ((n % 2) == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32768) begin
        sum = 64'sd32768;
      end
      tab[k] = sum[WAVE_BITS-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_tab();

  logic [1:0]           quad;
  logic [R_BITS-1:0]    r;
  logic [SEL_BITS-1:0]  sel;
  logic [WAVE_BITS-1:0] sine_mag;
  logic [15:0]          p16;
  logic [WAVE_BITS-1:0] abs_d;
  logic [WAVE_BITS-1:0] u_nxt;
  logic [WAVE_BITS-1:0] u_r;
  logic                 valid_r;
  logic                 advance;

  assign quad = phase[PHASE_BITS-1 -: 2];
  assign r    = phase[PHASE_BITS-3 -: R_BITS];
  assign sel  = quad[0] ? (SEL_BITS'(QUARTER) - {1'b0, r}) : {1'b0, r};
  assign sine_mag = SINE_TAB[sel];

  assign p16 = phase[PHASE_BITS-1 -: 16];
  // |p16 - 32768|, which reaches 32768 at phase zero.
  assign abs_d = p16[15] ? {2'b00, p16[14:0]} : (ONE_Q15 - {1'b0, p16});

  always_comb begin
    case (wave_shape)
      WAVE_SINE:     u_nxt = quad[1] ? (ONE_Q15 - sine_mag) : (ONE_Q15 + sine_mag);
      WAVE_SQUARE:   u_nxt = phase[PHASE_BITS-1] ? '0 : FULL_Q15;
      WAVE_SAWTOOTH: u_nxt = {1'b0, p16};
      WAVE_TRIANGLE: u_nxt = {abs_d[WAVE_BITS-2:0], 1'b0};
      default:       u_nxt = ONE_Q15;
    endcase
  end

  assign advance     = !valid_r || wave_ready;
  assign phase_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= phase_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && phase_valid) begin
      u_r <= u_nxt;
    end
  end

  assign wave_valid = valid_r;
  assign wave_u     = u_r;

endmodule

>>> src/dds_scale.sv
module dds_scale #(
  parameter int CODE_BITS = 11,
  parameter int PEAK_BITS = 11
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wave_valid,
  input  logic [dds_pkg::WAVE_BITS-1:0]  wave_u,
  output logic                           wave_ready,
  input  logic [PEAK_BITS-1:0]           peak_code,
  output logic                           code_valid,
  output logic [CODE_BITS-1:0]           code,
  input  logic                           code_ready
);
  import dds_pkg::*;

  localparam int PROD_BITS = PEAK_BITS + WAVE_BITS + 1;

  logic [PROD_BITS-1:0] prod;
  logic [CODE_BITS-1:0] code_r;
  logic                 valid_r;
  logic                 advance;

  // Rounded peak * u / 65536; never exceeds the peak code.
  assign prod = PROD_BITS'(peak_code) * PROD_BITS'(wave_u) + PROD_BITS'(ONE_Q15);

  assign advance    = !valid_r || code_ready;
  assign wave_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= wave_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wave_valid) begin
      code_r <= prod[16 +: CODE_BITS];
    end
  end

  assign code_valid = valid_r;
  assign code       = code_r;

endmodule

>>> src/dds_waveform_generator.sv
// Direct digital synthesis drive-wave generator.
//
// Each beat on the in_ stream is one sample tick; in_tdata[0] is the restart
// flag, which clears the phase before that sample. For every input beat the
// block returns exactly one beat on the out_ stream carrying an unsigned DAC
// code between zero and the configured peak code.
//
// There are three register stages: a phase register, a wave register (table
// lookup or shape logic) and a code register after the peak multiply, in that
// order. Throughput is one sample per clock while out_tready is high; each
// stage moves whenever it is empty or the stage after it takes its beat, so a
// stall at out_tready backs up through the three stages before in_tready drops.
//
// Registers are written through cfg_wen/cfg_index/cfg_wdata: 0 phase step,
// 1 wave shape, 2 peak code; other indexes are ignored. The user must write
// them only while the stream is idle; the block itself does not enforce it.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the phase and
// loads the default step, sine shape and peak code.
module dds_waveform_generator #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int CODE_BITS        = 11
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [0] restart
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((CODE_BITS + 7) / 8) * 8-1:0] out_tdata,  // sample_code
  input  logic                                 cfg_wen,
  input  logic [dds_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [dds_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import dds_pkg::*;

  localparam int OUT_BITS  = ((CODE_BITS + 7) / 8) * 8;
  localparam int PEAK_BITS = (CODE_BITS > PEAK_RESET_BITS) ? CODE_BITS : PEAK_RESET_BITS;

  logic [STEP_BITS-1:0]  phase_step_r;
  wave_shape_t           wave_shape_r;
  logic [PEAK_BITS-1:0]  peak_code_r;

  logic                  phase_valid;
  logic                  phase_ready;
  logic [PHASE_BITS-1:0] phase;
  logic                  wave_valid;
  logic                  wave_ready;
  logic [WAVE_BITS-1:0]  wave_u;
  logic [CODE_BITS-1:0]  code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= STEP_RESET;
      wave_shape_r <= WAVE_SINE;
      peak_code_r  <= PEAK_BITS'(PEAK_RESET);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_PHASE_STEP: phase_step_r <= cfg_wdata[STEP_BITS-1:0];
        CFG_WAVE_SHAPE: wave_shape_r <= wave_shape_t'(cfg_wdata[1:0]);
        CFG_PEAK_CODE:  peak_code_r  <= PEAK_BITS'(cfg_wdata[CODE_BITS-1:0]);
        default: ;
      endcase
    end
  end

  dds_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .restart     (in_tdata[0]),
    .in_ready    (in_tready),
    .phase_step  (phase_step_r),
    .phase_valid (phase_valid),
    .phase       (phase),
    .phase_ready (phase_ready)
  );

  dds_wave #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_wave (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_valid (phase_valid),
    .phase       (phase),
    .phase_ready (phase_ready),
    .wave_shape  (wave_shape_r),
    .wave_valid  (wave_valid),
    .wave_u      (wave_u),
    .wave_ready  (wave_ready)
  );

  dds_scale #(
    .CODE_BITS (CODE_BITS),
    .PEAK_BITS (PEAK_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .wave_valid (wave_valid),
    .wave_u     (wave_u),
    .wave_ready (wave_ready),
    .peak_code  (peak_code_r),
    .code_valid (out_tvalid),
    .code       (code),
    .code_ready (out_tready)
  );

  assign out_tdata = OUT_BITS'(code);

endmodule

>>> tb/sv/dds_waveform_generator_tb.sv
module dds_waveform_generator_tb;
  import dds_pkg::*;

  localparam int CODE_W = 11;
  localparam int OUT_W = 16;
  localparam int QTR = 64;
  localparam int LATENCY = 3;
  localparam int MAX_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1750;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata = '0;      // [0] restart
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_W-1:0]         out_tdata;          // [10:0] sample_code
  logic                     cfg_wen = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // Model state: quarter-wave sine, registers and phase accumulator.
  int                quarter_sine[QTR+1];
  logic [31:0]       tone_step;
  wave_shape_t       tone_shape;
  logic [CODE_W-1:0] tone_peak;
  logic [31:0]       tone_phase;

  logic              pending_restarts[$];
  logic [CODE_W-1:0] expected_codes[$];
  bit                idle_on;
  int                in_gap;
  int                out_hold;
  int                out_draw;
  int                errors;
  int                cycles;

  dds_waveform_generator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Taylor series for sin in unsigned Q30, rounded to the nearest Q15 value.
  function automatic void build_quarter_sine();
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    for (int k = 0; k <= QTR; k++) begin
      x = (PI_Q30 * longint'(k) + QTR) / (2 * QTR);
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum -= longint'(term);
        end else begin
          sum += longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) / 32768;
      if (sum > 32768) sum = 32768;
      quarter_sine[k] = int'(sum);
    end
  endfunction

  function automatic logic [CODE_W-1:0] next_sample_code(logic restart);
    int              w;
    int              d;
    int              r;
    int              p16;
    longint unsigned u;
    longint unsigned code;
    if (restart) tone_phase = '0;
    p16 = tone_phase[31:16];
    d = p16 - 32768;
    r = tone_phase[29:24];
    case (tone_shape)
      WAVE_SINE: begin
        case (tone_phase[31:30])
          2'd0: w = quarter_sine[r];
          2'd1: w = quarter_sine[QTR - r];
          2'd2: w = -quarter_sine[r];
          default: w = -quarter_sine[QTR - r];
        endcase
      end
      WAVE_SQUARE: w = tone_phase[31] ? -32768 : 32768;
      WAVE_SAWTOOTH: w = d;
      default: w = 2 * (d < 0 ? -d : d) - 32768;
    endcase
    u = longint'(w + 32768);
    code = (longint'(tone_peak) * u + 32768) >> 16;
    tone_phase = tone_phase + tone_step;
    return code[CODE_W-1:0];
  endfunction

  function automatic void log_mismatch(string what, logic [OUT_W-1:0] want,
                                       logic [OUT_W-1:0] got);
    if (errors < 10) $display("mismatch (%s): expected %0d, got %0d", what, want, got);
    errors++;
  endfunction

  // Driver: a new beat is offered once the current one is taken and the drawn
  // gap has run out.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_codes.push_back(next_sample_code(in_tdata[0]));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_restarts.size() != 0) begin
          in_tdata <= {7'b0, pending_restarts.pop_front()};
          in_tvalid <= 1'b1;
          in_gap <= idle_on ? $urandom_range(0, 10) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and draws a stall after it.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_codes.size() == 0) begin
          log_mismatch("no beat expected", '0, out_tdata);
        end else begin
          logic [CODE_W-1:0] want;
          want = expected_codes.pop_front();
          if (out_tdata !== {{(OUT_W-CODE_W){1'b0}}, want})
            log_mismatch("sample_code", {{(OUT_W-CODE_W){1'b0}}, want}, out_tdata);
        end
        out_draw = idle_on ? $urandom_range(0, 10) : 0;
        out_hold <= out_draw;
        out_tready <= (out_draw == 0);
      end else if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_tready <= (out_hold == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      CFG_PHASE_STEP: tone_step = value;
      CFG_WAVE_SHAPE: tone_shape = wave_shape_t'(value[1:0]);
      CFG_PEAK_CODE: tone_peak = value[CODE_W-1:0];
      default: ;
    endcase
  endtask

  // Returns once the stream is empty and the pipeline has had time to settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_restarts.size() != 0 || in_tvalid || expected_codes.size() != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic run_phase(int n_items, bit restart_first, int restart_pct);
    @(negedge clk);
    for (int i = 0; i < n_items; i++)
      pending_restarts.push_back((i == 0 && restart_first) || $urandom_range(0, 99) < restart_pct);
    wait_drained();
  endtask

  task automatic randomize_config();
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 7))
        0: write_reg(CFG_PHASE_STEP, 32'h0000_0000);
        1: write_reg(CFG_PHASE_STEP, 32'h8000_0000);
        2: write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        3: write_reg(CFG_PHASE_STEP, $urandom_range(1, 4096));
        4: write_reg(CFG_PHASE_STEP, $urandom_range(1, 32'h0400_0000));
        default: write_reg(CFG_PHASE_STEP, $urandom);
      endcase
    end
    if ($urandom_range(0, 3) != 0) write_reg(CFG_WAVE_SHAPE, $urandom);
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0: write_reg(CFG_PEAK_CODE, 32'd0);
        1: write_reg(CFG_PEAK_CODE, 32'h7FF);
        default: write_reg(CFG_PEAK_CODE, $urandom);
      endcase
    end
    if ($urandom_range(0, 5) == 0) write_reg(CFG_UNUSED, $urandom);
  endtask

  initial begin
    int items_sent;
    int n;
    build_quarter_sine();
    tone_step = STEP_RESET;
    tone_shape = WAVE_SINE;
    tone_peak = PEAK_RESET;
    tone_phase = '0;
    idle_on = 1'b0;
    errors = 0;
    cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values first, then each shape at full scale with coarse steps.
    run_phase(4, 1'b0, 0);
    idle_on = 1'b1;
    write_reg(CFG_WAVE_SHAPE, 32'(WAVE_SQUARE));
    write_reg(CFG_PHASE_STEP, 32'h8000_0000);
    write_reg(CFG_PEAK_CODE, 32'd2047);
    run_phase(3, 1'b1, 0);
    write_reg(CFG_WAVE_SHAPE, 32'(WAVE_SAWTOOTH));
    write_reg(CFG_PHASE_STEP, 32'h4000_0000);
    run_phase(4, 1'b1, 0);
    write_reg(CFG_WAVE_SHAPE, 32'(WAVE_TRIANGLE));
    write_reg(CFG_PHASE_STEP, 32'h2000_0000);
    run_phase(5, 1'b1, 0);
    write_reg(CFG_WAVE_SHAPE, 32'(WAVE_SINE));
    write_reg(CFG_PHASE_STEP, 32'h1000_0000);
    run_phase(5, 1'b1, 0);
    // Zero peak with a step that wraps the accumulator on every sample.
    write_reg(CFG_PEAK_CODE, 32'd0);
    write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    run_phase(2, 1'b0, 0);
    // Bits above each register's width are dropped; index 3 is not a register.
    write_reg(CFG_WAVE_SHAPE, 32'hFFFF_FFF5);
    write_reg(CFG_PEAK_CODE, 32'hA5A5_A401);
    write_reg(CFG_UNUSED, 32'h0000_0000);
    write_reg(CFG_PHASE_STEP, 32'h0000_0000);
    run_phase(2, 1'b0, 0);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      n = $urandom_range(20, 150);
      randomize_config();
      idle_on = ($urandom_range(0, 3) != 0);
      run_phase(n, $urandom_range(0, 1), $urandom_range(0, 8));
      items_sent += n;
    end

    wait_drained();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> dds_waveform_generator.f
src/dds_pkg.sv
src/dds_phase.sv
src/dds_wave.sv
src/dds_scale.sv
src/dds_waveform_generator.sv
tb/sv/dds_waveform_generator_tb.sv
